/* design/azdq_pkg.sv */
`timescale 1ns / 1ps

package azdq_pkg;

    localparam int SENSOR_COUNT      = 8;
    localparam int DOOR_INDEX        = 0;
    localparam int EMERGENCY_INDEX   = 1;
    localparam int FIXED_DELAY_TICKS = 30;

    // The masks are eight bits wide, so at most eight sensors exist.
    localparam int MASK_W  = 8;
    localparam int LANES   = (SENSOR_COUNT < MASK_W) ? SENSOR_COUNT : MASK_W;
    localparam int COUNT_W = 13;
    localparam int SECS_W  = 8;
    localparam int CFG_W   = 8;
    localparam int INDEX_W = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_W   = 24;

    localparam logic [COUNT_W-1:0] FIXED_LOAD = COUNT_W'(FIXED_DELAY_TICKS);

    // Door delay is seconds * 1000 / 33 ticks. The divide by 33 is a multiply by
    // ceil(2^23 / 33) and a shift; the error stays below one for all 8-bit seconds.
    localparam int RECIP_SHIFT = 23;
    localparam longint RECIP_M = ((64'd1 << RECIP_SHIFT) + 64'd32) / 64'd33;
    localparam int DOOR_SCALE_W = 28;
    localparam logic [DOOR_SCALE_W-1:0] DOOR_SCALE = DOOR_SCALE_W'(RECIP_M * 1000);
    localparam logic [SECS_W-1:0] DOOR_SECS_RESET = SECS_W'(30);
    localparam logic [COUNT_W-1:0] DOOR_LOAD_RESET = COUNT_W'(30 * 1000 / 33);

    typedef enum logic [INDEX_W-1:0] {
        REG_ENABLED   = 2'd0,
        REG_NORMAL    = 2'd1,
        REG_DOOR_SECS = 2'd2,
        REG_UNUSED    = 2'd3
    } t_reg_index;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_ORDINARY  = 2'd1,
        STATUS_EMERGENCY = 2'd2
    } t_status;

    typedef struct packed {
        logic step;        // a word is accepted this cycle
        logic enabled;     // sensor is armed
        logic off_normal;  // sampled level differs from the idle level
        logic en_change;   // enable write flips this sensor's bit
        logic en_next;     // enable bit after that write
    } t_lane_ctl;

    function automatic logic [COUNT_W-1:0] door_ticks(input logic [SECS_W-1:0] secs);
        logic [SECS_W+DOOR_SCALE_W-1:0] prod;
        prod = (SECS_W+DOOR_SCALE_W)'(secs) * (SECS_W+DOOR_SCALE_W)'(DOOR_SCALE);
        return prod[RECIP_SHIFT +: COUNT_W];
    endfunction

    function automatic logic [LANES-1:0] lane_bit(input int idx);
        logic [LANES-1:0] m;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            m[i] = (i == idx);
        end
        return m;
    endfunction

endpackage

/* design/alarm_zone_delay_qualifier.sv */
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its sensor word is accepted.
// Throughput: one word per cycle while the output is taken; every sensor lane updates its counter in the
// same cycle, and the output register is refilled whenever it is taken.
// Reset (synchronous, active low) clears all delays and latches, disables every
// sensor, sets the normal levels to zero and the door delay to 30 seconds.
module alarm_zone_delay_qualifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [7:0] sensor_levels
    input  logic [7:0]                    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [1:0] alarm_status, [9:2] alarm_mask, [17:10] new_alarm_mask, [23:18] zero
    output logic [azdq_pkg::OUT_W-1:0]    o_m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [azdq_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [azdq_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import azdq_pkg::*;

    logic [LANES-1:0]   r_enabled;
    logic [LANES-1:0]   r_normal;
    logic [COUNT_W-1:0] r_door_load;
    logic               w_step;
    logic               w_en_wr;
    logic [LANES-1:0]   w_latch;
    logic [LANES-1:0]   w_fresh;
    t_reg_index         w_index;

    assign w_index         = t_reg_index'(i_cfg_index);
    assign o_s_axis_tready = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_step          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_en_wr         = i_cfg_wr_en && (w_index == REG_ENABLED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= '0;
            r_normal    <= '0;
            r_door_load <= DOOR_LOAD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (w_index)
                REG_ENABLED:   r_enabled <= i_cfg_wdata[LANES-1:0];
                REG_NORMAL:    r_normal  <= i_cfg_wdata[LANES-1:0];
                REG_DOOR_SECS: begin
                    r_door_load <= door_ticks(i_cfg_wdata[SECS_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        t_lane_ctl          w_ctl;
        logic [COUNT_W-1:0] w_load;

        assign w_load = (g == DOOR_INDEX) ? r_door_load : FIXED_LOAD;

        always_comb begin
            w_ctl.step       = w_step;
            w_ctl.enabled    = r_enabled[g];
            w_ctl.off_normal = i_s_axis_tdata[g] ^ r_normal[g];
            w_ctl.en_change  = w_en_wr && (i_cfg_wdata[g] != r_enabled[g]);
            w_ctl.en_next    = i_cfg_wdata[g];
        end

        azdq_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_load       (w_load),
            .o_latch_next (w_latch[g]),
            .o_fresh      (w_fresh[g])
        );
    end

    azdq_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_latch         (w_latch),
        .i_fresh         (w_fresh),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A newly latched sensor is always part of the latched mask.
    a_fresh_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[STATUS_W+MASK_W +: MASK_W]
                              & ~o_m_axis_tdata[STATUS_W +: MASK_W]) == '0))
        else $error("new alarm bit outside the latched mask");

    // Status reports an alarm exactly when some sensor is latched.
    a_status_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[STATUS_W-1:0] == STATUS_NONE)
                             == (o_m_axis_tdata[STATUS_W +: MASK_W] == '0)))
        else $error("alarm status disagrees with the latched mask");

    // Sensor 0, once disabled, holds no latch after the enable write has landed.
    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en_wr |=> ((g_lane[0].u_lane.r_latch == 1'b0) || r_enabled[0]))
        else $error("latch survived disabling its sensor");
`endif

endmodule

/* design/azdq_lane.sv */
`timescale 1ns / 1ps

module azdq_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  azdq_pkg::t_lane_ctl          i_ctl,
    input  logic [azdq_pkg::COUNT_W-1:0] i_load,
    output logic                         o_latch_next,
    output logic                         o_fresh
);
    import azdq_pkg::*;

    logic               r_running, n_running;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic               r_latch,   n_latch;

    always_comb begin
        n_running = r_running;
        n_count   = r_count;
        n_latch   = r_latch;
        o_fresh   = 1'b0;
        if (i_ctl.en_change) begin
            n_running = 1'b0;
            n_count   = '0;
            if (!i_ctl.en_next) begin
                n_latch = 1'b0;
            end
        end else if (i_ctl.step && i_ctl.enabled) begin
            if (i_ctl.off_normal) begin
                if (!r_running) begin
                    n_running = 1'b1;
                    n_count   = i_load;
                end else if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
                if ((n_count == '0) && !r_latch) begin
                    n_latch = 1'b1;
                    o_fresh = 1'b1;
                end
            end else if (!r_latch) begin
                n_running = 1'b0;
                n_count   = '0;
            end
        end
    end

    assign o_latch_next = n_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_count   <= '0;
            r_latch   <= 1'b0;
        end else begin
            r_running <= n_running;
            r_count   <= n_count;
            r_latch   <= n_latch;
        end
    end

endmodule

/* design/azdq_merge.sv */
`timescale 1ns / 1ps

module azdq_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [azdq_pkg::LANES-1:0] i_latch,
    input  logic [azdq_pkg::LANES-1:0] i_fresh,
    input  logic                       i_m_axis_tready,
    output logic                       o_m_axis_tvalid,
    output logic [azdq_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import azdq_pkg::*;

    localparam logic [LANES-1:0] EMERG_BIT = lane_bit(EMERGENCY_INDEX);

    logic                r_valid, n_valid;
    logic [OUT_W-1:0]    r_data,  n_data;
    t_status             w_status;

    always_comb begin
        if ((i_latch & EMERG_BIT) != '0) begin
            w_status = STATUS_EMERGENCY;
        end else if (i_latch != '0) begin
            w_status = STATUS_ORDINARY;
        end else begin
            w_status = STATUS_NONE;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_step) begin
            n_valid = 1'b1;
            n_data  = {OUT_W'(0)};
            n_data[STATUS_W-1:0]               = w_status;
            n_data[STATUS_W +: MASK_W]         = MASK_W'(i_latch);
            n_data[STATUS_W+MASK_W +: MASK_W]  = MASK_W'(i_fresh);
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule
